// ===== src/ehmab_pkg.sv =====
package ehmab_pkg;

    // default build values
    localparam int WINDOW_MAX      = 64;
    localparam int SAMPLE_BITS     = 16;
    localparam int COEFF_FRAC_BITS = 15;

    // filter state carries 8 fraction bits below the sample
    localparam int STATE_FRAC = 8;

    // register file layout
    localparam int COEFF_W    = 16;
    localparam int WLEN_W     = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [COEFF_W-1:0] COEFF_RESET = 16'd27853;
    localparam logic [WLEN_W-1:0]  WLEN_RESET  = 7'd10;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LPF_COEFF     = 3'd0,
        REG_HPF_COEFF     = 3'd1,
        REG_LPF_ENABLE    = 3'd2,
        REG_HPF_ENABLE    = 3'd3,
        REG_AVG_ENABLE    = 3'd4,
        REG_WINDOW_LENGTH = 3'd5
    } t_reg_idx;

endpackage

// ===== src/ehmab_ifs.sv =====
interface ehmab_in_if #(
    parameter int SAMPLE_BITS = ehmab_pkg::SAMPLE_BITS
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface ehmab_out_if #(
    parameter int SAMPLE_BITS = ehmab_pkg::SAMPLE_BITS
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] lowpass_out;
    logic                          lowpass_valid;
    logic signed [SAMPLE_BITS-1:0] highpass_out;
    logic                          highpass_valid;
    logic signed [SAMPLE_BITS-1:0] average_out;
    logic                          average_valid;

    modport source (
        output valid, output lowpass_out, output lowpass_valid,
        output highpass_out, output highpass_valid,
        output average_out, output average_valid,
        input  ready
    );
    modport sink (
        input  valid, input lowpass_out, input lowpass_valid,
        input  highpass_out, input highpass_valid,
        input  average_out, input average_valid,
        output ready
    );
endinterface

interface ehmab_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [ehmab_pkg::CFG_IDX_W-1:0]     index;
    logic [ehmab_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/ema_highpass_moving_average_bank.sv =====
// Filter bank: each sample word runs through an exponential low-pass, an exponential
// high-pass (sample minus its running average) and a moving average over the last
// window_length samples, each with its own enable; a disabled filter holds its state
// and returns zero with its valid bit low. Each accepted sample runs through a multiply
// for each exponential filter on a single shared multiplier, then a two-bits-per-cycle
// divider for the average, then into the output register, which it enters only when
// no previous result is held there; no new sample is accepted before that. A new
// sample is taken while the previous result still waits there. The window samples
// live in one memory with a registered read; a fill count marks entries written since
// the last clear, so reset and writes to avg_enable or window_length need no clearing
// pass. The config port is always ready; the user must write it only while the block is
// idle, and the block itself does not enforce this.
module ema_highpass_moving_average_bank #(
    parameter int WINDOW_MAX      = ehmab_pkg::WINDOW_MAX,
    parameter int SAMPLE_BITS     = ehmab_pkg::SAMPLE_BITS,
    parameter int COEFF_FRAC_BITS = ehmab_pkg::COEFF_FRAC_BITS
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ehmab_cfg_if.sink    i_cfg,
    ehmab_in_if.sink     i_smp,
    ehmab_out_if.source  o_res
);

    localparam int SB       = SAMPLE_BITS;
    localparam int SF       = ehmab_pkg::STATE_FRAC;
    localparam int CW       = ehmab_pkg::COEFF_W;
    localparam int ST_W     = SB + SF;
    localparam int CF_W     = COEFF_FRAC_BITS + 1;
    localparam int CMP_W    = (CF_W > CW) ? CF_W : CW;
    localparam int DIFF_W   = ST_W + 1;
    localparam int PROD_W   = CF_W + 1 + DIFF_W;
    localparam int ACC_W    = PROD_W + 1;
    localparam int A_W      = $clog2(WINDOW_MAX);
    localparam int L_W      = $clog2(WINDOW_MAX + 1);
    localparam int LC_W     = (L_W > ehmab_pkg::WLEN_W) ? L_W : ehmab_pkg::WLEN_W;
    localparam int SUM_W    = SB + A_W;
    localparam int DIV_BITS = 2;
    localparam int MAG_W    = ((SUM_W + DIV_BITS - 1) / DIV_BITS) * DIV_BITS;
    localparam int DIV_CYC  = MAG_W / DIV_BITS;
    localparam int DC_W     = $clog2(DIV_CYC);

    localparam logic [CF_W-1:0]         COEFF_ONE = {1'b1, {COEFF_FRAC_BITS{1'b0}}};
    localparam logic signed [ACC_W-1:0] RND_C     = ACC_W'(1) << (COEFF_FRAC_BITS - 1);
    localparam logic signed [ST_W:0]    RND_LO    = (ST_W + 1)'(1) << (SF - 1);
    localparam logic signed [ST_W+1:0]  RND_HI    = (ST_W + 2)'(1) << (SF - 1);
    localparam logic signed [SB-1:0]    SMP_MAX   = {1'b0, {(SB - 1){1'b1}}};
    localparam logic signed [SB-1:0]    SMP_MIN   = {1'b1, {(SB - 1){1'b0}}};

    typedef enum logic [2:0] {
        S_IDLE,
        S_LP,
        S_HP,
        S_DIV,
        S_OUT
    } t_state;

    // configuration
    logic [CW-1:0]                    r_lpf_coeff;
    logic [CW-1:0]                    r_hpf_coeff;
    logic                             r_lpf_en;
    logic                             r_hpf_en;
    logic                             r_avg_en;
    logic [ehmab_pkg::WLEN_W-1:0]     r_wlen;

    // filter state
    logic signed [ST_W-1:0]           r_lp_prev;
    logic signed [ST_W-1:0]           r_hp_prev;
    logic signed [SUM_W-1:0]          r_sum;
    logic [A_W-1:0]                   r_head;
    logic [L_W-1:0]                   r_fill;

    // window memory
    logic signed [SB-1:0]             r_win [WINDOW_MAX];
    logic signed [SB-1:0]             r_win_rd;
    logic                             r_old_ok;

    // datapath
    t_state                           r_state;
    logic signed [SB-1:0]             r_x;
    logic signed [PROD_W-1:0]         r_prod;
    logic [L_W-1:0]                   r_div_rem;
    logic [MAG_W-1:0]                 r_div_q;
    logic                             r_div_neg;
    logic [DC_W-1:0]                  r_div_cnt;

    // output register
    logic                             r_out_valid;
    logic signed [SB-1:0]             r_out_lo;
    logic                             r_out_lo_v;
    logic signed [SB-1:0]             r_out_hi;
    logic                             r_out_hi_v;
    logic signed [SB-1:0]             r_out_av;
    logic                             r_out_av_v;

    logic                             cfg_fire;
    logic                             smp_fire;
    logic [CF_W-1:0]                  a_lp;
    logic [CF_W-1:0]                  a_hp;
    logic signed [ST_W-1:0]           xs;
    logic [CF_W-1:0]                  mul_a;
    logic signed [DIFF_W-1:0]         mul_d;
    logic signed [PROD_W-1:0]         n_prod;
    logic signed [ST_W-1:0]           upd_base;
    logic signed [ACC_W-1:0]          acc;
    logic signed [ST_W-1:0]           n_flt;
    logic [LC_W-1:0]                  wl_ext;
    logic [L_W-1:0]                   win_len;
    logic [L_W:0]                     old_t;
    logic [A_W-1:0]                   rd_addr;
    logic signed [SB-1:0]             old_smp;
    logic signed [SUM_W-1:0]          n_sum;
    logic [A_W-1:0]                   n_head;
    logic [L_W-1:0]                   n_fill;
    logic [SUM_W-1:0]                 sum_abs;
    logic [L_W:0]                     div_t;
    logic [L_W-1:0]                   n_rem;
    logic [MAG_W-1:0]                 n_q;
    logic                             div_first;
    logic signed [ST_W:0]             lo_rnd;
    logic signed [SB:0]               lo_v;
    logic signed [SB-1:0]             lo_sat;
    logic signed [ST_W+1:0]           hi_rnd;
    logic signed [SB+1:0]             hi_v;
    logic signed [SB-1:0]             hi_sat;
    logic signed [MAG_W:0]            q_s;
    logic signed [SB-1:0]             av_sat;

    assign cfg_fire    = i_cfg.valid && i_cfg.ready;
    assign smp_fire    = i_smp.valid && i_smp.ready;
    assign i_cfg.ready = 1'b1;
    assign i_smp.ready = (r_state == S_IDLE);

    // coefficients above one act as one
    assign a_lp = (CMP_W'(r_lpf_coeff) > CMP_W'(COEFF_ONE)) ? COEFF_ONE : CF_W'(r_lpf_coeff);
    assign a_hp = (CMP_W'(r_hpf_coeff) > CMP_W'(COEFF_ONE)) ? COEFF_ONE : CF_W'(r_hpf_coeff);

    assign xs = {r_x, {SF{1'b0}}};

    // low-pass: one*xs + a*(prev - xs); high-pass average: one*b + a*(xs - b)
    always_comb begin
        if (r_state == S_LP) begin
            mul_a = a_lp;
            mul_d = DIFF_W'(r_lp_prev) - DIFF_W'(xs);
        end else begin
            mul_a = a_hp;
            mul_d = DIFF_W'(xs) - DIFF_W'(r_hp_prev);
        end
    end

    assign n_prod = PROD_W'($signed({1'b0, mul_a})) * PROD_W'(mul_d);

    assign upd_base = (r_state == S_HP) ? xs : r_hp_prev;
    assign acc      = (ACC_W'(upd_base) <<< COEFF_FRAC_BITS) + ACC_W'(r_prod) + RND_C;
    assign n_flt    = acc[COEFF_FRAC_BITS +: ST_W];

    // window length clamped to 1..WINDOW_MAX
    assign wl_ext = LC_W'(r_wlen);
    always_comb begin
        if (wl_ext == '0) begin
            win_len = L_W'(1);
        end else if (wl_ext > LC_W'(WINDOW_MAX)) begin
            win_len = L_W'(WINDOW_MAX);
        end else begin
            win_len = L_W'(wl_ext);
        end
    end

    // address of the sample leaving the window
    assign old_t   = (L_W + 1)'(r_head) - (L_W + 1)'(win_len);
    assign rd_addr = old_t[L_W] ? A_W'(old_t + (L_W + 1)'(WINDOW_MAX)) : A_W'(old_t);

    assign old_smp = r_old_ok ? r_win_rd : '0;
    assign n_sum   = r_sum - SUM_W'(old_smp) + SUM_W'(r_x);
    assign n_head  = (r_head == A_W'(WINDOW_MAX - 1)) ? '0 : r_head + 1'b1;
    assign n_fill  = (r_fill == L_W'(WINDOW_MAX)) ? r_fill : r_fill + 1'b1;

    assign sum_abs = r_sum[SUM_W-1] ? (~r_sum + 1'b1) : r_sum;

    // restoring divide, dividend shifts out of the top of q as quotient bits enter
    always_comb begin
        n_rem = r_div_rem;
        n_q   = r_div_q;
        div_t = '0;
        for (int k = 0; k < DIV_BITS; k++) begin
            div_t = {n_rem, n_q[MAG_W-1]};
            n_q   = {n_q[MAG_W-2:0], 1'b0};
            if (div_t >= (L_W + 1)'(win_len)) begin
                div_t  = div_t - (L_W + 1)'(win_len);
                n_q[0] = 1'b1;
            end
            n_rem = div_t[L_W-1:0];
        end
    end

    assign div_first = (r_state == S_DIV) && (r_div_cnt == DC_W'(DIV_CYC - 1));

    // results back to sample format with saturation
    assign lo_rnd = (ST_W + 1)'(r_lp_prev) + RND_LO;
    assign lo_v   = lo_rnd[ST_W:SF];
    assign lo_sat = (lo_v[SB] == lo_v[SB-1]) ? lo_v[SB-1:0] : (lo_v[SB] ? SMP_MIN : SMP_MAX);

    assign hi_rnd = (ST_W + 2)'(xs) - (ST_W + 2)'(r_hp_prev) + RND_HI;
    assign hi_v   = hi_rnd[ST_W+1:SF];
    assign hi_sat = ((&hi_v[SB+1:SB-1]) || !(|hi_v[SB+1:SB-1])) ? hi_v[SB-1:0]
                  : (hi_v[SB+1] ? SMP_MIN : SMP_MAX);

    assign q_s    = r_div_neg ? -$signed({1'b0, r_div_q}) : $signed({1'b0, r_div_q});
    assign av_sat = ((&q_s[MAG_W:SB-1]) || !(|q_s[MAG_W:SB-1])) ? q_s[SB-1:0]
                  : (q_s[MAG_W] ? SMP_MIN : SMP_MAX);

    // configuration and filter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lpf_coeff <= ehmab_pkg::COEFF_RESET;
            r_hpf_coeff <= ehmab_pkg::COEFF_RESET;
            r_lpf_en    <= 1'b0;
            r_hpf_en    <= 1'b0;
            r_avg_en    <= 1'b0;
            r_wlen      <= ehmab_pkg::WLEN_RESET;
            r_lp_prev   <= '0;
            r_hp_prev   <= '0;
            r_sum       <= '0;
            r_head      <= '0;
            r_fill      <= '0;
        end else begin
            if (cfg_fire) begin
                case (ehmab_pkg::t_reg_idx'(i_cfg.index))
                    ehmab_pkg::REG_LPF_COEFF: begin
                        r_lpf_coeff <= i_cfg.data[CW-1:0];
                    end
                    ehmab_pkg::REG_HPF_COEFF: begin
                        r_hpf_coeff <= i_cfg.data[CW-1:0];
                    end
                    ehmab_pkg::REG_LPF_ENABLE: begin
                        r_lpf_en <= i_cfg.data[0];
                    end
                    ehmab_pkg::REG_HPF_ENABLE: begin
                        r_hpf_en <= i_cfg.data[0];
                    end
                    ehmab_pkg::REG_AVG_ENABLE: begin
                        r_avg_en <= i_cfg.data[0];
                        r_sum    <= '0;
                        r_head   <= '0;
                        r_fill   <= '0;
                    end
                    ehmab_pkg::REG_WINDOW_LENGTH: begin
                        r_wlen <= i_cfg.data[ehmab_pkg::WLEN_W-1:0];
                        r_sum  <= '0;
                        r_head <= '0;
                        r_fill <= '0;
                    end
                    default: begin
                    end
                endcase
            end
            if (r_state == S_LP && r_avg_en) begin
                r_sum  <= n_sum;
                r_head <= n_head;
                r_fill <= n_fill;
            end
            if (r_state == S_HP && r_lpf_en) begin
                r_lp_prev <= n_flt;
            end
            if (div_first && r_hpf_en) begin
                r_hp_prev <= n_flt;
            end
        end
    end

    // sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (smp_fire) begin
                        r_state <= S_LP;
                    end
                end
                S_LP: begin
                    r_state <= S_HP;
                end
                S_HP: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (r_div_cnt == '0) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_out_valid || o_res.ready) begin
                        r_state     <= S_IDLE;
                        r_out_valid <= 1'b1;
                        r_out_lo    <= r_lpf_en ? lo_sat : '0;
                        r_out_lo_v  <= r_lpf_en;
                        r_out_hi    <= r_hpf_en ? hi_sat : '0;
                        r_out_hi_v  <= r_hpf_en;
                        r_out_av    <= r_avg_en ? av_sat : '0;
                        r_out_av_v  <= r_avg_en;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // window memory and datapath registers
    always_ff @(posedge i_clk) begin
        if (smp_fire) begin
            r_x      <= i_smp.sample;
            r_win_rd <= r_win[rd_addr];
            r_old_ok <= (r_fill > L_W'(rd_addr));
        end
        if (r_state == S_LP && r_avg_en) begin
            r_win[r_head] <= r_x;
        end
        if (r_state == S_LP || r_state == S_HP) begin
            r_prod <= n_prod;
        end
        if (r_state == S_HP) begin
            r_div_rem <= '0;
            r_div_q   <= MAG_W'(sum_abs);
            r_div_neg <= r_sum[SUM_W-1];
            r_div_cnt <= DC_W'(DIV_CYC - 1);
        end else if (r_state == S_DIV) begin
            r_div_rem <= n_rem;
            r_div_q   <= n_q;
            r_div_cnt <= r_div_cnt - 1'b1;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.lowpass_out    = r_out_lo;
    assign o_res.lowpass_valid  = r_out_lo_v;
    assign o_res.highpass_out   = r_out_hi;
    assign o_res.highpass_valid = r_out_hi_v;
    assign o_res.average_out    = r_out_av;
    assign o_res.average_valid  = r_out_av_v;

`ifndef SYNTH
    // a window register write empties the window
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cfg_fire && (ehmab_pkg::t_reg_idx'(i_cfg.index) == ehmab_pkg::REG_AVG_ENABLE ||
                      ehmab_pkg::t_reg_idx'(i_cfg.index) == ehmab_pkg::REG_WINDOW_LENGTH))
        |=> (r_fill == '0 && r_head == '0 && r_sum == '0))
        else $error("window not cleared after window register write");

    // head follows the fill count until the memory has wrapped
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill <= L_W'(WINDOW_MAX)) &&
        ((r_fill == L_W'(WINDOW_MAX)) || (L_W'(r_head) == r_fill)))
        else $error("window head and fill count disagree");

    // a finished result waits while the previous word is still held
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_out_valid && !o_res.ready) |=> (r_state == S_OUT))
        else $error("pending result overwritten");
`endif

endmodule
